[src/midi_track_event_parser_defines.svh]
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// General property check, clocked on the rising edge and held off during reset.
`define MTEP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mtep: property failed");
// Condition that must never be seen at a clock edge.
`define MTEP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mtep: forbidden condition seen");
`else
`define MTEP_ASSERT(label, clk, rst_n, prop)
`define MTEP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[src/mtep_pkg.sv]
package mtep_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_BODY_BYTE   = 2'd0;
    localparam logic [1:0] OP_START_TRACK = 2'd1;
    localparam logic [1:0] OP_START_FILE  = 2'd2;

    // Result record kinds.
    localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
    localparam logic [2:0] KIND_AFTERTOUCH = 3'd2;
    localparam logic [2:0] KIND_CONTROL    = 3'd3;
    localparam logic [2:0] KIND_PROGRAM    = 3'd4;
    localparam logic [2:0] KIND_TEMPO      = 3'd5;
    localparam logic [2:0] KIND_END_TRACK  = 3'd6;
    localparam logic [2:0] KIND_STRAY      = 3'd7;

    // Upper nibbles of channel status bytes.
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_AFTERTOUCH = 4'hA;
    localparam logic [3:0] HI_CONTROL    = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    // System status bytes and meta types of interest.
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [7:0] META_END_TRACK    = 8'h2F;
    localparam logic [7:0] META_SET_TEMPO    = 8'h51;

    localparam logic [23:0] TEMPO_DEFAULT    = 24'd500000;
    localparam logic [7:0]  TEMPO_BODY_BYTES = 8'd3;

    // Parser phase, one-hot.
    typedef enum logic [8:0] {
        PH_DELTA  = 9'b000000001,
        PH_STATUS = 9'b000000010,
        PH_DATA1  = 9'b000000100,
        PH_DATA2  = 9'b000001000,
        PH_SYSLEN = 9'b000010000,
        PH_SKIP   = 9'b000100000,
        PH_MTYPE  = 9'b001000000,
        PH_MLEN   = 9'b010000000,
        PH_TEMPO  = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [27:0] delta_ticks;
        logic [31:0] absolute_ticks;
        logic [23:0] tempo_us;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   track_ended;
    } t_status;

endpackage

[src/mtep_in_if.sv]
// Byte channel into the parser.
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

[src/mtep_out_if.sv]
// Event record channel out of the parser.
interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic [27:0] delta_ticks;
    logic [31:0] absolute_ticks;
    logic [23:0] tempo_us;

    modport source (
        output valid, output kind, output channel, output first_value,
        output second_value, output delta_ticks, output absolute_ticks,
        output tempo_us, input ready
    );
    modport sink (
        input valid, input kind, input channel, input first_value,
        input second_value, input delta_ticks, input absolute_ticks,
        input tempo_us, output ready
    );
endinterface

[src/midi_track_event_parser.sv]
// A byte word passes through the input register and its result word, if any, through the
// result register. Throughput: one byte word per cycle unless the result register stalls;
// each byte is one step of the parser state.
// An input register and a result register separate the two channels, so a new
// byte is taken while a finished record still waits to be taken.
// Reset (synchronous, active low) empties both registers, clears the track state
// and sets the tempo to 500000 microseconds per quarter note.
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtep_in_if.sink     i_in,
    mtep_out_if.source  o_out
);

    logic              r_in_valid;
    logic [1:0]        r_op;
    logic [7:0]        r_byte;
    logic              r_out_valid;
    mtep_pkg::t_result r_out;

    logic              w_advance;
    logic              w_out_stalled;
    logic              w_start;
    logic              w_res_valid;
    mtep_pkg::t_result w_res;
    mtep_pkg::t_status w_stat;

    // The held byte is processed when the result register is free or draining.
    assign w_out_stalled = r_out_valid && !o_out.ready;
    assign w_advance     = r_in_valid && !w_out_stalled;
    assign i_in.ready    = !r_in_valid || w_advance;

    // A track or file start is being processed this cycle.
    assign w_start = w_advance && (r_op == mtep_pkg::OP_START_TRACK ||
                                  r_op == mtep_pkg::OP_START_FILE);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.op;
            r_byte <= i_in.data_byte;
        end
    end

    mtep_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_op        (r_op),
        .i_byte      (r_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.channel        = r_out.channel;
    assign o_out.first_value    = r_out.first_value;
    assign o_out.second_value   = r_out.second_value;
    assign o_out.delta_ticks    = r_out.delta_ticks;
    assign o_out.absolute_ticks = r_out.absolute_ticks;
    assign o_out.tempo_us       = r_out.tempo_us;

    // No record may come from a track that has already ended.
    `MTEP_ASSERT_NEVER(a_no_record_after_end, i_clk, i_rst_n, w_res_valid && w_stat.track_ended)
    // A track or file start leaves the parser decoding a fresh delta.
    `MTEP_ASSERT(a_start_resets_track, i_clk, i_rst_n, w_start |=> w_stat.phase == mtep_pkg::PH_DELTA)
    // Input back-pressure only arises from a full, stalled result register.
    `MTEP_ASSERT(a_stall_cause, i_clk, i_rst_n, !i_in.ready |-> r_in_valid && w_out_stalled)

endmodule

[src/mtep_core.sv]
// Track parser state and the per-byte step logic.
module mtep_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_byte,
    output logic               o_res_valid,
    output mtep_pkg::t_result  o_res,
    output mtep_pkg::t_status  o_stat
);

    mtep_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_current, n_current;
    logic [27:0] r_delta, n_delta;
    logic [31:0] r_tick, n_tick;
    logic [23:0] r_tempo, n_tempo;
    logic [7:0]  r_meta, n_meta;
    logic [27:0] r_len, n_len;
    logic [7:0]  r_held, n_held;
    logic        r_ended, n_ended;

    // Result fields chosen by the step logic.
    logic        w_emit;
    logic [2:0]  w_kind;
    logic [3:0]  w_chan;
    logic [7:0]  w_first;
    logic [7:0]  w_second;

    // Shifted varlen values and the channel status in force for a first data byte.
    logic [27:0] w_delta_shift;
    logic [27:0] w_len_shift;
    logic [27:0] w_len_dec;
    logic [7:0]  w_status;

    assign w_delta_shift = {r_delta[20:0], i_byte[6:0]};
    assign w_len_shift   = {r_len[20:0], i_byte[6:0]};
    assign w_len_dec     = r_len - 28'd1;
    assign w_status      = (r_phase == mtep_pkg::PH_STATUS) ? r_running : r_current;

    // One parser step per accepted word.
    always_comb begin
        n_phase   = r_phase;
        n_running = r_running;
        n_current = r_current;
        n_delta   = r_delta;
        n_tick    = r_tick;
        n_tempo   = r_tempo;
        n_meta    = r_meta;
        n_len     = r_len;
        n_held    = r_held;
        n_ended   = r_ended;
        w_emit    = 1'b0;
        w_kind    = mtep_pkg::KIND_NOTE_OFF;
        w_chan    = 4'd0;
        w_first   = 8'd0;
        w_second  = 8'd0;

        if (i_step && (i_op == mtep_pkg::OP_START_TRACK || i_op == mtep_pkg::OP_START_FILE)) begin
            n_phase   = mtep_pkg::PH_DELTA;
            n_running = 8'd0;
            n_current = 8'd0;
            n_delta   = 28'd0;
            n_tick    = 32'd0;
            n_meta    = 8'd0;
            n_len     = 28'd0;
            n_held    = 8'd0;
            n_ended   = 1'b0;
            if (i_op == mtep_pkg::OP_START_FILE) begin
                n_tempo = mtep_pkg::TEMPO_DEFAULT;
            end
        end else if (i_step && i_op == mtep_pkg::OP_BODY_BYTE && !r_ended) begin
            unique case (r_phase)
                mtep_pkg::PH_DELTA: begin
                    n_delta = w_delta_shift;
                    if (!i_byte[7]) begin
                        n_tick  = r_tick + {4'd0, w_delta_shift};
                        n_phase = mtep_pkg::PH_STATUS;
                    end
                end
                mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1: begin
                    if (r_phase == mtep_pkg::PH_STATUS && i_byte[7]) begin
                        // A new status byte.
                        n_current = i_byte;
                        if (i_byte[7:4] != mtep_pkg::HI_SYSTEM) begin
                            n_running = i_byte;
                            n_phase   = mtep_pkg::PH_DATA1;
                        end else begin
                            n_running = 8'd0;
                            if (i_byte == mtep_pkg::STATUS_SYSEX ||
                                i_byte == mtep_pkg::STATUS_SYSEX_CONT) begin
                                n_len   = 28'd0;
                                n_phase = mtep_pkg::PH_SYSLEN;
                            end else if (i_byte == mtep_pkg::STATUS_META) begin
                                n_phase = mtep_pkg::PH_MTYPE;
                            end else begin
                                n_phase = mtep_pkg::PH_DELTA;
                                n_delta = 28'd0;
                            end
                        end
                    end else if (r_phase == mtep_pkg::PH_STATUS && r_running == 8'd0) begin
                        // Data byte with no running status in force.
                        w_emit  = 1'b1;
                        w_kind  = mtep_pkg::KIND_STRAY;
                        w_first = i_byte;
                        n_phase = mtep_pkg::PH_DELTA;
                        n_delta = 28'd0;
                    end else begin
                        // First data byte, explicit or under running status.
                        n_current = w_status;
                        n_held    = i_byte;
                        if (w_status[7:4] == mtep_pkg::HI_PROGRAM) begin
                            w_emit  = 1'b1;
                            w_kind  = mtep_pkg::KIND_PROGRAM;
                            w_chan  = w_status[3:0];
                            w_first = i_byte;
                            n_phase = mtep_pkg::PH_DELTA;
                            n_delta = 28'd0;
                        end else if (w_status[7:4] == mtep_pkg::HI_PRESSURE) begin
                            n_phase = mtep_pkg::PH_DELTA;
                            n_delta = 28'd0;
                        end else begin
                            n_phase = mtep_pkg::PH_DATA2;
                        end
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    w_chan   = r_current[3:0];
                    w_first  = r_held;
                    w_second = i_byte;
                    case (r_current[7:4])
                        mtep_pkg::HI_NOTE_OFF: begin
                            w_emit = 1'b1;
                            w_kind = mtep_pkg::KIND_NOTE_OFF;
                        end
                        mtep_pkg::HI_NOTE_ON: begin
                            w_emit = 1'b1;
                            w_kind = (i_byte != 8'd0) ? mtep_pkg::KIND_NOTE_ON
                                                      : mtep_pkg::KIND_NOTE_OFF;
                        end
                        mtep_pkg::HI_AFTERTOUCH: begin
                            w_emit = 1'b1;
                            w_kind = mtep_pkg::KIND_AFTERTOUCH;
                        end
                        mtep_pkg::HI_CONTROL: begin
                            w_emit = 1'b1;
                            w_kind = mtep_pkg::KIND_CONTROL;
                        end
                        default: begin
                            w_emit = 1'b0;
                        end
                    endcase
                    n_phase = mtep_pkg::PH_DELTA;
                    n_delta = 28'd0;
                end
                mtep_pkg::PH_SYSLEN: begin
                    n_len = w_len_shift;
                    if (!i_byte[7]) begin
                        if (w_len_shift != 28'd0) begin
                            n_phase = mtep_pkg::PH_SKIP;
                        end else begin
                            n_phase = mtep_pkg::PH_DELTA;
                            n_delta = 28'd0;
                        end
                    end
                end
                mtep_pkg::PH_SKIP: begin
                    n_len = w_len_dec;
                    if (w_len_dec == 28'd0) begin
                        n_phase = mtep_pkg::PH_DELTA;
                        n_delta = 28'd0;
                    end
                end
                mtep_pkg::PH_MTYPE: begin
                    n_meta  = i_byte;
                    n_len   = 28'd0;
                    n_phase = mtep_pkg::PH_MLEN;
                end
                mtep_pkg::PH_MLEN: begin
                    n_len = w_len_shift;
                    if (!i_byte[7]) begin
                        if (r_meta == mtep_pkg::META_END_TRACK) begin
                            n_ended = 1'b1;
                            w_emit  = 1'b1;
                            w_kind  = mtep_pkg::KIND_END_TRACK;
                            n_phase = mtep_pkg::PH_DELTA;
                            n_delta = 28'd0;
                        end else if (r_meta == mtep_pkg::META_SET_TEMPO) begin
                            n_held = 8'd0;
                            if (w_len_shift == 28'd0) begin
                                w_emit  = 1'b1;
                                w_kind  = mtep_pkg::KIND_TEMPO;
                                n_phase = mtep_pkg::PH_DELTA;
                                n_delta = 28'd0;
                            end else begin
                                n_tempo = 24'd0;
                                n_phase = mtep_pkg::PH_TEMPO;
                            end
                        end else if (w_len_shift != 28'd0) begin
                            n_phase = mtep_pkg::PH_SKIP;
                        end else begin
                            n_phase = mtep_pkg::PH_DELTA;
                            n_delta = 28'd0;
                        end
                    end
                end
                mtep_pkg::PH_TEMPO: begin
                    // Only the first three body bytes form the tempo.
                    if (r_held < mtep_pkg::TEMPO_BODY_BYTES) begin
                        n_tempo = {r_tempo[15:0], i_byte};
                        n_held  = r_held + 8'd1;
                    end
                    n_len = w_len_dec;
                    if (w_len_dec == 28'd0) begin
                        w_emit  = 1'b1;
                        w_kind  = mtep_pkg::KIND_TEMPO;
                        n_phase = mtep_pkg::PH_DELTA;
                        n_delta = 28'd0;
                    end
                end
                default: begin
                    n_phase = mtep_pkg::PH_DELTA;
                    n_delta = 28'd0;
                end
            endcase
        end
    end

    // Records carry the delta and tick sum of the event and the updated tempo.
    assign o_res_valid          = w_emit;
    assign o_res.kind           = w_kind;
    assign o_res.channel        = w_chan;
    assign o_res.first_value    = w_first;
    assign o_res.second_value   = w_second;
    assign o_res.delta_ticks    = r_delta;
    assign o_res.absolute_ticks = r_tick;
    assign o_res.tempo_us       = n_tempo;

    assign o_stat.phase       = r_phase;
    assign o_stat.track_ended = r_ended;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_running <= 8'd0;
            r_current <= 8'd0;
            r_delta   <= 28'd0;
            r_tick    <= 32'd0;
            r_tempo   <= mtep_pkg::TEMPO_DEFAULT;
            r_meta    <= 8'd0;
            r_len     <= 28'd0;
            r_held    <= 8'd0;
            r_ended   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_current <= n_current;
            r_delta   <= n_delta;
            r_tick    <= n_tick;
            r_tempo   <= n_tempo;
            r_meta    <= n_meta;
            r_len     <= n_len;
            r_held    <= n_held;
            r_ended   <= n_ended;
        end
    end

endmodule
